// ----- design/acps_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the antialiased circle pixel shader.
// Used by every module of the shader; depends on nothing else.
package acps_pkg;

  // Fixed widths of the register and payload fields.
  localparam int COORD_W   = 12;
  localparam int COLOR_W   = 24;
  localparam int DIM_W     = 9;
  localparam int PX_W      = 10;
  localparam int PY_W      = 8;
  localparam int CHAN_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = COLOR_W;

  // Bounding box arithmetic is done in signed whole-pixel units.
  localparam int BOX_W = COORD_W + 3;

  // Distances and coverage coefficients carry eight fraction bits.
  localparam int SHADE_FRAC = 8;
  localparam int COEFF_W    = SHADE_FRAC + 1;
  localparam int DIST_ONE   = 1 << SHADE_FRAC;
  // Inner edge of the outline ring, 1.5 in Q.8.
  localparam int DIST_RING  = DIST_ONE + DIST_ONE / 2;

  // Column wraparound works on the magnitude of pixel_x.
  localparam int WRAP_W = PX_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_RADIUS       = 3'd2,
    REG_COLOR        = 3'd3,
    REG_FILL_MODE    = 3'd4,
    REG_FRAME_WIDTH  = 3'd5,
    REG_FRAME_HEIGHT = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [COORD_W-1:0] radius;
    logic [COLOR_W-1:0] color;
    logic               fill_mode;
    logic [DIM_W-1:0]   frame_width;
    logic [DIM_W-1:0]   frame_height;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    center_x:     12'd0,
    center_y:     12'd0,
    radius:       12'd0,
    color:        24'hFFFFFF,
    fill_mode:    1'b1,
    frame_width:  9'd256,
    frame_height: 9'd256
  };

  // Per-pixel data that rides along the square root pipeline.
  typedef struct packed {
    logic            in_box;
    logic            neg;
    logic [PY_W-1:0] py;
  } side_t;

  // Running state of the column remainder computation.
  typedef struct packed {
    logic [WRAP_W-1:0] mag;
    logic [WRAP_W-1:0] rem;
  } wrap_t;

endpackage

// ----- design/acps_front.sv -----
`timescale 1ns / 1ps
// Front end of the shader: bounding box test, offsets from the center,
// squares and the scaled squared distance. Three register stages; uses acps_pkg.
module acps_front import acps_pkg::*; #(
  parameter int COORD_FRAC_BITS = 4,
  parameter int A_W = 14,
  parameter int ROOT_W = 19
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  cfg_t                   cfg,
  input  logic [DIM_W-1:0]       h_eff,
  input  logic                   in_valid,
  input  logic signed [PX_W-1:0] px,
  input  logic [PY_W-1:0]        py,
  output logic                   out_valid,
  output logic [2*ROOT_W-1:0]    out_s,
  output side_t                  out_side,
  output wrap_t                  out_wrap
);

  localparam int AS_W = A_W + 1;
  localparam int SQ_W = 2 * A_W;
  localparam int SUM_W = SQ_W + 1;
  localparam int ROOT2_W = 2 * ROOT_W;
  localparam int SCALE_SHIFT = 2 * SHADE_FRAC - 2 * COORD_FRAC_BITS;
  localparam logic signed [BOX_W-1:0] BOX_ONE = BOX_W'(1);
  localparam logic signed [BOX_W-1:0] BOX_MASK = BOX_W'((1 << COORD_FRAC_BITS) - 1);

  logic signed [BOX_W-1:0] x_diff, x_sum, y_diff, y_sum;
  logic signed [BOX_W-1:0] x_lo, x_hi, y_lo, y_hi;
  logic signed [BOX_W-1:0] px_b, py_b;
  logic                    row_ok, in_box;
  logic signed [AS_W-1:0]  a_next, b_next;
  logic [WRAP_W-1:0]       px_u, mag_next;
  side_t                   side_next;

  // Stage 1 registers.
  logic                   valid1;
  logic signed [AS_W-1:0] a1, b1;
  side_t                  side1;
  logic [WRAP_W-1:0]      mag1;
  // Stage 2 registers.
  logic                   valid2;
  logic [SQ_W-1:0]        asq2, bsq2;
  side_t                  side2;
  logic [WRAP_W-1:0]      mag2;

  logic signed [2*AS_W-1:0] prod_a, prod_b;
  logic [SUM_W-1:0]         sq_sum;

  always_comb begin
    // Box edges in whole pixels: floor(c - r) - 1 and ceil(c + r) + 1.
    x_diff = $signed(BOX_W'(cfg.center_x)) - $signed(BOX_W'(cfg.radius));
    x_sum  = $signed(BOX_W'(cfg.center_x)) + $signed(BOX_W'(cfg.radius));
    y_diff = $signed(BOX_W'(cfg.center_y)) - $signed(BOX_W'(cfg.radius));
    y_sum  = $signed(BOX_W'(cfg.center_y)) + $signed(BOX_W'(cfg.radius));
    x_lo = (x_diff >>> COORD_FRAC_BITS) - BOX_ONE;
    x_hi = ((x_sum + BOX_MASK) >>> COORD_FRAC_BITS) + BOX_ONE;
    y_lo = (y_diff >>> COORD_FRAC_BITS) - BOX_ONE;
    y_hi = ((y_sum + BOX_MASK) >>> COORD_FRAC_BITS) + BOX_ONE;
    px_b = BOX_W'(px);
    py_b = $signed(BOX_W'(py));
    // The last frame row is never drawn.
    row_ok = (WRAP_W'(py) + WRAP_W'(1)) < WRAP_W'(h_eff);
    in_box = (px_b >= x_lo) && (px_b < x_hi) && (py_b >= y_lo) && (py_b < y_hi)
             && row_ok;

    a_next = ($signed(AS_W'(px)) <<< COORD_FRAC_BITS) - $signed(AS_W'(cfg.center_x));
    b_next = ($signed(AS_W'(py)) <<< COORD_FRAC_BITS) - $signed(AS_W'(cfg.center_y));

    px_u = px;
    mag_next = px_u[WRAP_W-1] ? (~px_u + WRAP_W'(1)) : px_u;
    side_next.in_box = in_box;
    side_next.neg = px_u[WRAP_W-1];
    side_next.py = py;
  end

  always_comb begin
    prod_a = a1 * a1;
    prod_b = b1 * b1;
    sq_sum = SUM_W'(asq2) + SUM_W'(bsq2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      valid1 <= in_valid;
      valid2 <= valid1;
      out_valid <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a1 <= a_next;
      b1 <= b_next;
      side1 <= side_next;
      mag1 <= mag_next;

      asq2 <= prod_a[SQ_W-1:0];
      bsq2 <= prod_b[SQ_W-1:0];
      side2 <= side1;
      mag2 <= mag1;

      out_s <= ROOT2_W'(sq_sum) << SCALE_SHIFT;
      out_side <= side2;
      out_wrap.mag <= mag2;
      out_wrap.rem <= '0;
    end
  end

endmodule

// ----- design/acps_root_step.sv -----
`timescale 1ns / 1ps
// One stage of the square root pipeline: retires one root bit per pixel and,
// when enabled, one bit of the column remainder. Uses acps_pkg.
module acps_root_step import acps_pkg::*; #(
  parameter int ROOT_W = 19,
  parameter bit MOD_EN = 1'b1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic [DIM_W-1:0]      w_eff,
  input  logic                  in_valid,
  input  logic [2*ROOT_W-1:0]   in_s,
  input  logic [ROOT_W-1:0]     in_root,
  input  logic [ROOT_W+1:0]     in_rem,
  input  side_t                 in_side,
  input  wrap_t                 in_wrap,
  output logic                  out_valid,
  output logic [2*ROOT_W-1:0]   out_s,
  output logic [ROOT_W-1:0]     out_root,
  output logic [ROOT_W+1:0]     out_rem,
  output side_t                 out_side,
  output wrap_t                 out_wrap
);

  localparam int REM_W = ROOT_W + 2;
  localparam int ROOT2_W = 2 * ROOT_W;

  logic [REM_W-1:0]   rem_sh, trial, rem_next;
  logic               take;
  logic [ROOT_W-1:0]  root_next;
  logic [ROOT2_W-1:0] s_next;
  wrap_t              wrap_next;

  always_comb begin
    // Bring down the next pair of radicand bits and try root*4 + 1.
    rem_sh = {in_rem[REM_W-3:0], in_s[ROOT2_W-1 -: 2]};
    trial = {in_root, 2'b01};
    take = rem_sh >= trial;
    rem_next = take ? (rem_sh - trial) : rem_sh;
    root_next = {in_root[ROOT_W-2:0], take};
    s_next = in_s << 2;
  end

  generate
    if (MOD_EN) begin : g_mod
      logic [WRAP_W-1:0] wrem_sh;
      always_comb begin
        wrem_sh = {in_wrap.rem[WRAP_W-2:0], in_wrap.mag[WRAP_W-1]};
        wrap_next.mag = in_wrap.mag << 1;
        wrap_next.rem = (wrem_sh >= WRAP_W'(w_eff)) ? (wrem_sh - WRAP_W'(w_eff)) : wrem_sh;
      end
    end else begin : g_pass
      always_comb begin
        wrap_next = in_wrap;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_s <= s_next;
      out_root <= root_next;
      out_rem <= rem_next;
      out_side <= in_side;
      out_wrap <= wrap_next;
    end
  end

endmodule

// ----- design/acps_shade.sv -----
`timescale 1ns / 1ps
// Back end of the shader: edge distance, coverage coefficient, column wrap,
// then color scaling into the output registers. Two stages; uses acps_pkg.
module acps_shade import acps_pkg::*; #(
  parameter int COORD_FRAC_BITS = 4,
  parameter int ROOT_W = 19
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  cfg_t              cfg,
  input  logic [DIM_W-1:0]  w_eff,
  input  logic              in_valid,
  input  logic [ROOT_W-1:0] in_root,
  input  side_t             in_side,
  input  wrap_t             in_wrap,
  output logic              result_valid,
  output logic              write_pixel,
  output logic [CHAN_W-1:0] column,
  output logic [PY_W-1:0]   row,
  output logic [CHAN_W-1:0] red,
  output logic [CHAN_W-1:0] green,
  output logic [CHAN_W-1:0] blue
);

  localparam int RS_W = COORD_W + SHADE_FRAC - COORD_FRAC_BITS;
  localparam int D_W = ((ROOT_W > RS_W) ? ROOT_W : RS_W) + 1;
  localparam int PROD_W = CHAN_W + COEFF_W;
  localparam logic signed [D_W-1:0] D_ONE = D_W'(DIST_ONE);
  localparam logic signed [D_W-1:0] D_RING_NEG = -D_W'(DIST_RING);
  localparam logic signed [D_W-1:0] D_ONE_NEG = -D_W'(DIST_ONE);
  localparam logic signed [D_W-1:0] D_ZERO = '0;

  logic signed [D_W-1:0] root_d, edge_d, c_pos, c_neg;
  logic [RS_W-1:0]       r_scaled;
  logic                  write_next;
  logic [COEFF_W-1:0]    coeff_raw, coeff_next;
  logic [WRAP_W-1:0]     col_next;

  logic                 valid_a, write_a;
  logic [COEFF_W-1:0]   coeff_a;
  logic [WRAP_W-1:0]    col_a;
  logic [PY_W-1:0]      row_a;
  logic [PROD_W-1:0]    prod_r, prod_g, prod_b;

  always_comb begin
    r_scaled = RS_W'(cfg.radius) << (SHADE_FRAC - COORD_FRAC_BITS);
    root_d = $signed(D_W'(in_root));
    edge_d = root_d - $signed(D_W'(r_scaled));
    c_pos = D_ONE - edge_d;
    c_neg = D_ONE + edge_d;

    // Outline mode accepts the band between -1.5 and 1 only.
    write_next = in_side.in_box && (edge_d < D_ONE) &&
                 (cfg.fill_mode || (edge_d > D_RING_NEG));

    if (edge_d > D_ZERO) begin
      coeff_raw = COEFF_W'(c_pos);
    end else if (cfg.fill_mode) begin
      coeff_raw = COEFF_W'(DIST_ONE);
    end else if (edge_d > D_ONE_NEG) begin
      coeff_raw = COEFF_W'(c_neg);
    end else begin
      // Deep inside the ring the coefficient clamps to zero: drawn in black.
      coeff_raw = '0;
    end
    coeff_next = write_next ? coeff_raw : '0;

    col_next = (in_side.neg && (in_wrap.rem != '0)) ?
               (WRAP_W'(w_eff) - in_wrap.rem) : in_wrap.rem;
  end

  always_comb begin
    prod_r = PROD_W'(cfg.color[3*CHAN_W-1 -: CHAN_W]) * PROD_W'(coeff_a);
    prod_g = PROD_W'(cfg.color[2*CHAN_W-1 -: CHAN_W]) * PROD_W'(coeff_a);
    prod_b = PROD_W'(cfg.color[CHAN_W-1 -: CHAN_W]) * PROD_W'(coeff_a);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      valid_a <= in_valid;
      result_valid <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      write_a <= write_next;
      coeff_a <= coeff_next;
      col_a <= col_next;
      row_a <= in_side.py;

      write_pixel <= write_a;
      column <= col_a[CHAN_W-1:0];
      row <= row_a;
      red <= prod_r[SHADE_FRAC +: CHAN_W];
      green <= prod_g[SHADE_FRAC +: CHAN_W];
      blue <= prod_b[SHADE_FRAC +: CHAN_W];
    end
  end

endmodule

// ----- design/antialiased_circle_pixel_shader_core.sv -----
`timescale 1ns / 1ps
// A transaction passes acps_front, the square root stages and acps_shade on its way to result_valid;
// one that arrives during a hold waits in the skid register first. Throughput: one pixel per clock
// unless result_stall holds the pipeline; the square root takes one stage per root bit.
// Reset clears the pipeline and skid register and loads the register defaults.
// Depends on acps_pkg, acps_front, acps_root_step and acps_shade.
module antialiased_circle_pixel_shader_core import acps_pkg::*; #(
  parameter int MAX_DIM = 256,
  parameter int COORD_FRAC_BITS = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   pixel_valid,
  output logic                   pixel_stall,
  input  logic signed [PX_W-1:0] pixel_x,
  input  logic [PY_W-1:0]        pixel_y,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic                   write_pixel,
  output logic [CHAN_W-1:0]      column,
  output logic [PY_W-1:0]        row,
  output logic [CHAN_W-1:0]      red,
  output logic [CHAN_W-1:0]      green,
  output logic [CHAN_W-1:0]      blue
);

  localparam int A_MAX = (1 << (PX_W - 1)) * (1 << COORD_FRAC_BITS) + (1 << COORD_W) - 1;
  localparam int A_W = $clog2(A_MAX + 1);
  localparam int S_W = 2 * A_W + 1 + 2 * SHADE_FRAC - 2 * COORD_FRAC_BITS;
  localparam int ROOT_W = (S_W + 1) / 2;
  localparam int ROOT2_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  cfg_t cfg;
  logic [DIM_W-1:0] w_clamp, w_eff, h_eff;
  logic advance;

  logic                   skid_full;
  logic signed [PX_W-1:0] skid_x;
  logic [PY_W-1:0]        skid_y;
  logic                   ent_valid;
  logic signed [PX_W-1:0] ent_x;
  logic [PY_W-1:0]        ent_y;

  logic               st_valid [ROOT_W+1];
  logic [ROOT2_W-1:0] st_s     [ROOT_W+1];
  logic [ROOT_W-1:0]  st_root  [ROOT_W+1];
  logic [REM_W-1:0]   st_rem   [ROOT_W+1];
  side_t              st_side  [ROOT_W+1];
  wrap_t              st_wrap  [ROOT_W+1];

  // Register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTER_X:     cfg.center_x <= cfg_data[COORD_W-1:0];
        REG_CENTER_Y:     cfg.center_y <= cfg_data[COORD_W-1:0];
        REG_RADIUS:       cfg.radius <= cfg_data[COORD_W-1:0];
        REG_COLOR:        cfg.color <= cfg_data[COLOR_W-1:0];
        REG_FILL_MODE:    cfg.fill_mode <= cfg_data[0];
        REG_FRAME_WIDTH:  cfg.frame_width <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Frame sizes above MAX_DIM act as MAX_DIM; a zero width acts as one.
  always_comb begin
    w_clamp = (int'(cfg.frame_width) > MAX_DIM) ? DIM_W'(MAX_DIM) : cfg.frame_width;
    w_eff = (w_clamp == '0) ? DIM_W'(1) : w_clamp;
    h_eff = (int'(cfg.frame_height) > MAX_DIM) ? DIM_W'(MAX_DIM) : cfg.frame_height;
  end

  // The whole pipeline holds while a finished result waits downstream.
  assign advance = !(result_valid && result_stall);
  assign pixel_stall = skid_full;

  // The skid register catches a transaction that arrives during a hold.
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (advance) begin
      skid_full <= 1'b0;
    end else if (pixel_valid && !skid_full) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!advance && pixel_valid && !skid_full) begin
      skid_x <= pixel_x;
      skid_y <= pixel_y;
    end
  end

  always_comb begin
    ent_valid = skid_full || pixel_valid;
    ent_x = skid_full ? skid_x : pixel_x;
    ent_y = skid_full ? skid_y : pixel_y;
  end

  acps_front #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .A_W(A_W),
    .ROOT_W(ROOT_W)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .advance(advance),
    .cfg(cfg),
    .h_eff(h_eff),
    .in_valid(ent_valid),
    .px(ent_x),
    .py(ent_y),
    .out_valid(st_valid[0]),
    .out_s(st_s[0]),
    .out_side(st_side[0]),
    .out_wrap(st_wrap[0])
  );

  assign st_root[0] = '0;
  assign st_rem[0] = '0;

  // The column remainder runs in the first WRAP_W stages, one bit per stage.
  generate
    for (genvar k = 0; k < ROOT_W; k++) begin : g_root
      acps_root_step #(
        .ROOT_W(ROOT_W),
        .MOD_EN(k < WRAP_W)
      ) u_step (
        .clk(clk),
        .rst(rst),
        .advance(advance),
        .w_eff(w_eff),
        .in_valid(st_valid[k]),
        .in_s(st_s[k]),
        .in_root(st_root[k]),
        .in_rem(st_rem[k]),
        .in_side(st_side[k]),
        .in_wrap(st_wrap[k]),
        .out_valid(st_valid[k+1]),
        .out_s(st_s[k+1]),
        .out_root(st_root[k+1]),
        .out_rem(st_rem[k+1]),
        .out_side(st_side[k+1]),
        .out_wrap(st_wrap[k+1])
      );
    end
  endgenerate

  acps_shade #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .ROOT_W(ROOT_W)
  ) u_shade (
    .clk(clk),
    .rst(rst),
    .advance(advance),
    .cfg(cfg),
    .w_eff(w_eff),
    .in_valid(st_valid[ROOT_W]),
    .in_root(st_root[ROOT_W]),
    .in_side(st_side[ROOT_W]),
    .in_wrap(st_wrap[ROOT_W]),
    .result_valid(result_valid),
    .write_pixel(write_pixel),
    .column(column),
    .row(row),
    .red(red),
    .green(green),
    .blue(blue)
  );

`ifndef SYNTH
  // The skid register only holds a transaction if the pipeline was held in the previous cycle.
  assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> $past(!advance))
    else $error("skid register filled while the pipeline was moving");

  // A pixel that is not written carries black.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !write_pixel) |-> (red == '0 && green == '0 && blue == '0))
    else $error("color on an unwritten pixel");

  // The wrapped column stays below the frame width when that fits the port.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && (w_eff <= DIM_W'(1 << CHAN_W))) |-> (DIM_W'(column) < w_eff))
    else $error("column outside the frame width");
`endif

endmodule
